FILE: rtl/lsw_pkg.sv
`timescale 1ns / 1ps

package lsw_pkg;

    // screen geometry
    localparam int MAX_COLS = 20;
    localparam int MAX_ROWS = 4;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int IDX_W    = $clog2(CELLS);

    // field widths
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 5;
    localparam int ROW_W  = 2;
    localparam int NCOL_W = 5;
    localparam int NROW_W = 3;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [NCOL_W-1:0] COLS_RESET = 5'd16;
    localparam logic [NROW_W-1:0] ROWS_RESET = 3'd2;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_NUM_COLS = 1'b0,
        REG_NUM_ROWS = 1'b1
    } t_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SETCUR = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_HOME   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_SETCUR = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_HOME   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CMP,
        S_DATA,
        S_CLEAR,
        S_ONE
    } t_state;

    // what the datapath loads into the result register
    typedef enum logic [1:0] {
        EM_NONE,
        EM_CURSOR,
        EM_DATA,
        EM_PASS
    } t_emit;

    // effective screen size
    typedef struct packed {
        logic [NCOL_W-1:0] cols;
        logic [NROW_W-1:0] rows;
    } t_cfg;

    typedef struct packed {
        logic  take;
        logic  sweep;
        logic  commit;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic stale;
        logic slot_free;
        logic sweep_done;
    } t_dp_stat;

endpackage

FILE: rtl/lsw_if.sv
`timescale 1ns / 1ps

interface lsw_req_if;
    logic                         valid;
    logic                         ready;
    logic [lsw_pkg::KIND_W-1:0]   kind;
    logic [lsw_pkg::CHAR_W-1:0]   char_code;
    logic [lsw_pkg::COL_W-1:0]    col;
    logic [lsw_pkg::ROW_W-1:0]    row;

    modport source (output valid, kind, char_code, col, row, input ready);
    modport sink   (input valid, kind, char_code, col, row, output ready);
endinterface

interface lsw_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [lsw_pkg::COL_W-1:0]    out_col;
    logic [lsw_pkg::ROW_W-1:0]    out_row;
    logic [lsw_pkg::CHAR_W-1:0]   out_char;
    logic                         last;

    modport source (output valid, command, out_col, out_row, out_char, last, input ready);
    modport sink   (input valid, command, out_col, out_row, out_char, last, output ready);
endinterface

FILE: rtl/lsw_regs.sv
`timescale 1ns / 1ps

module lsw_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsw_pkg::ADDR_W-1:0]   paddr,
    input  logic [lsw_pkg::DATA_W-1:0]   pwdata,
    output logic [lsw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output lsw_pkg::t_cfg                o_cfg
);

    logic [lsw_pkg::NCOL_W-1:0] r_num_cols;
    logic [lsw_pkg::NROW_W-1:0] r_num_rows;
    logic                       wr_en;
    lsw_pkg::t_reg              sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign sel    = lsw_pkg::t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= lsw_pkg::COLS_RESET;
            r_num_rows <= lsw_pkg::ROWS_RESET;
        end else if (wr_en) begin
            unique case (sel)
                lsw_pkg::REG_NUM_COLS: r_num_cols <= pwdata[lsw_pkg::NCOL_W-1:0];
                lsw_pkg::REG_NUM_ROWS: r_num_rows <= pwdata[lsw_pkg::NROW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            lsw_pkg::REG_NUM_COLS: prdata = lsw_pkg::DATA_W'(r_num_cols);
            lsw_pkg::REG_NUM_ROWS: prdata = lsw_pkg::DATA_W'(r_num_rows);
        endcase
    end

    // saturate to 1..max
    always_comb begin
        if (r_num_cols == '0)
            o_cfg.cols = lsw_pkg::NCOL_W'(1);
        else if (r_num_cols > lsw_pkg::NCOL_W'(lsw_pkg::MAX_COLS))
            o_cfg.cols = lsw_pkg::NCOL_W'(lsw_pkg::MAX_COLS);
        else
            o_cfg.cols = r_num_cols;

        if (r_num_rows == '0)
            o_cfg.rows = lsw_pkg::NROW_W'(1);
        else if (r_num_rows > lsw_pkg::NROW_W'(lsw_pkg::MAX_ROWS))
            o_cfg.rows = lsw_pkg::NROW_W'(lsw_pkg::MAX_ROWS);
        else
            o_cfg.rows = r_num_rows;
    end

endmodule

FILE: rtl/lsw_dp.sv
`timescale 1ns / 1ps

module lsw_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsw_pkg::t_dp_cmd            i_cmd,
    output lsw_pkg::t_dp_stat           o_stat,
    input  lsw_pkg::t_cfg               i_cfg,
    input  lsw_pkg::t_kind              i_kind,
    input  logic [lsw_pkg::CHAR_W-1:0]  i_char,
    input  logic [lsw_pkg::COL_W-1:0]   i_col,
    input  logic [lsw_pkg::ROW_W-1:0]   i_row,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_command,
    output logic [lsw_pkg::COL_W-1:0]   o_out_col,
    output logic [lsw_pkg::ROW_W-1:0]   o_out_row,
    output logic [lsw_pkg::CHAR_W-1:0]  o_out_char,
    output logic                        o_last
);

    // shadow screen
    logic [lsw_pkg::CHAR_W-1:0] r_mem [lsw_pkg::CELLS];
    logic [lsw_pkg::CHAR_W-1:0] r_rd_data;

    // latched request
    lsw_pkg::t_kind             r_kind;
    logic [lsw_pkg::CHAR_W-1:0] r_char;
    logic [lsw_pkg::COL_W-1:0]  r_in_col;
    logic [lsw_pkg::ROW_W-1:0]  r_in_row;

    // cursor
    logic [lsw_pkg::COL_W-1:0]  r_col, n_col;
    logic [lsw_pkg::ROW_W-1:0]  r_row, n_row;
    logic                       r_stale, n_stale;
    logic [lsw_pkg::IDX_W-1:0]  r_clr_idx;

    // result register
    logic                       r_out_valid;
    lsw_pkg::t_cmd              r_command, n_command;
    logic [lsw_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [lsw_pkg::ROW_W-1:0]  r_out_row, n_out_row;
    logic [lsw_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic                       r_last, n_last;

    logic [lsw_pkg::COL_W-1:0]  cols_m1;
    logic [lsw_pkg::NROW_W-1:0] rows_m1;
    logic [lsw_pkg::COL_W-1:0]  sat_col, set_col;
    logic [lsw_pkg::ROW_W-1:0]  sat_row, set_row;
    logic                       oob;
    logic [lsw_pkg::IDX_W-1:0]  idx;
    logic [lsw_pkg::COL_W:0]    col_inc;
    logic [lsw_pkg::NROW_W-1:0] row_inc;
    logic                       slot_free;

    assign cols_m1 = i_cfg.cols - lsw_pkg::COL_W'(1);
    assign rows_m1 = i_cfg.rows - lsw_pkg::NROW_W'(1);

    // cursor pulled back into the area in use
    assign sat_col = (r_col > cols_m1) ? cols_m1 : r_col;
    assign sat_row = (lsw_pkg::NROW_W'(r_row) > rows_m1) ? rows_m1[lsw_pkg::ROW_W-1:0] : r_row;
    assign oob     = (r_col > cols_m1) || (lsw_pkg::NROW_W'(r_row) > rows_m1);
    assign set_col = (r_in_col > cols_m1) ? cols_m1 : r_in_col;
    assign set_row = (lsw_pkg::NROW_W'(r_in_row) > rows_m1) ?
                     rows_m1[lsw_pkg::ROW_W-1:0] : r_in_row;

    // row-major cell address, stays below the cell count by construction
    assign idx = lsw_pkg::IDX_W'(sat_row) * lsw_pkg::IDX_W'(i_cfg.cols)
               + lsw_pkg::IDX_W'(sat_col);

    assign col_inc   = {1'b0, r_col} + (lsw_pkg::COL_W+1)'(1);
    assign row_inc   = lsw_pkg::NROW_W'(r_row) + lsw_pkg::NROW_W'(1);
    assign slot_free = !r_out_valid || i_out_ready;

    assign o_stat.match      = (r_rd_data == r_char);
    assign o_stat.stale      = r_stale;
    assign o_stat.slot_free  = slot_free;
    assign o_stat.sweep_done = (r_clr_idx == lsw_pkg::IDX_W'(lsw_pkg::CELLS - 1));

    // shadow store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep)
            r_mem[r_clr_idx] <= lsw_pkg::SPACE_CODE;
        else if (i_cmd.commit)
            r_mem[idx] <= r_char;
        if (i_cmd.take)
            r_rd_data <= r_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind   <= i_kind;
            r_char   <= i_char;
            r_in_col <= i_col;
            r_in_row <= i_row;
        end
    end

    // cursor next state
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_stale = r_stale;
        if (i_cmd.take && i_kind == lsw_pkg::KIND_WRITE) begin
            n_col   = sat_col;
            n_row   = sat_row;
            n_stale = r_stale | oob;
        end else if (i_cmd.commit) begin
            n_stale = o_stat.match;
            if (col_inc >= {1'b0, i_cfg.cols}) begin
                n_col   = '0;
                n_row   = (row_inc >= i_cfg.rows) ? '0 : row_inc[lsw_pkg::ROW_W-1:0];
                n_stale = 1'b1;
            end else begin
                n_col = col_inc[lsw_pkg::COL_W-1:0];
            end
        end else if (i_cmd.emit == lsw_pkg::EM_PASS) begin
            n_stale = 1'b0;
            if (r_kind == lsw_pkg::KIND_SETCUR) begin
                n_col = set_col;
                n_row = set_row;
            end else begin
                n_col = '0;
                n_row = '0;
            end
        end
    end

    // result payload
    always_comb begin
        n_command  = r_command;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_char = r_out_char;
        n_last     = r_last;
        unique case (i_cmd.emit)
            lsw_pkg::EM_NONE: begin
            end
            lsw_pkg::EM_CURSOR: begin
                n_command  = lsw_pkg::CMD_SETCUR;
                n_out_col  = r_col;
                n_out_row  = r_row;
                n_out_char = '0;
                n_last     = 1'b0;
            end
            lsw_pkg::EM_DATA: begin
                n_command  = lsw_pkg::CMD_DATA;
                n_out_col  = '0;
                n_out_row  = '0;
                n_out_char = r_char;
                n_last     = 1'b1;
            end
            lsw_pkg::EM_PASS: begin
                n_out_col  = '0;
                n_out_row  = '0;
                n_out_char = '0;
                n_last     = 1'b1;
                unique case (r_kind)
                    lsw_pkg::KIND_SETCUR: begin
                        n_command = lsw_pkg::CMD_SETCUR;
                        n_out_col = set_col;
                        n_out_row = set_row;
                    end
                    lsw_pkg::KIND_CLEAR: n_command = lsw_pkg::CMD_CLEAR;
                    lsw_pkg::KIND_HOME,
                    lsw_pkg::KIND_WRITE: n_command = lsw_pkg::CMD_HOME;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_command  <= n_command;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_char <= n_out_char;
        r_last     <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_stale     <= 1'b0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_stale <= n_stale;
            if (i_cmd.sweep)
                r_clr_idx <= o_stat.sweep_done ? '0 : r_clr_idx + lsw_pkg::IDX_W'(1);
            if (i_cmd.emit != lsw_pkg::EM_NONE)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_command   = r_command;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;

endmodule

FILE: rtl/lsw_ctrl.sv
`timescale 1ns / 1ps

module lsw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lsw_pkg::t_kind     i_kind,
    output logic               o_ready,
    output lsw_pkg::t_dp_cmd   o_cmd,
    input  lsw_pkg::t_dp_stat  i_stat
);

    lsw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= lsw_pkg::S_INIT;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd.take   = 1'b0;
        o_cmd.sweep  = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.emit   = lsw_pkg::EM_NONE;
        unique case (r_state)
            lsw_pkg::S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done)
                    n_state = lsw_pkg::S_IDLE;
            end
            lsw_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_kind)
                        lsw_pkg::KIND_WRITE:  n_state = lsw_pkg::S_CMP;
                        lsw_pkg::KIND_CLEAR:  n_state = lsw_pkg::S_CLEAR;
                        lsw_pkg::KIND_SETCUR,
                        lsw_pkg::KIND_HOME:   n_state = lsw_pkg::S_ONE;
                    endcase
                end
            end
            lsw_pkg::S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lsw_pkg::S_IDLE;
                end else if (i_stat.slot_free) begin
                    o_cmd.commit = 1'b1;
                    if (i_stat.stale) begin
                        o_cmd.emit = lsw_pkg::EM_CURSOR;
                        n_state    = lsw_pkg::S_DATA;
                    end else begin
                        o_cmd.emit = lsw_pkg::EM_DATA;
                        n_state    = lsw_pkg::S_IDLE;
                    end
                end
            end
            lsw_pkg::S_DATA: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = lsw_pkg::EM_DATA;
                    n_state    = lsw_pkg::S_IDLE;
                end
            end
            lsw_pkg::S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done)
                    n_state = lsw_pkg::S_ONE;
            end
            lsw_pkg::S_ONE: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = lsw_pkg::EM_PASS;
                    n_state    = lsw_pkg::S_IDLE;
                end
            end
            default: n_state = lsw_pkg::S_IDLE;
        endcase
    end

    a_write_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsw_pkg::S_IDLE && i_valid && i_kind == lsw_pkg::KIND_WRITE)
        |=> (r_state == lsw_pkg::S_CMP))
        else $error("write request did not reach compare");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit != lsw_pkg::EM_NONE) |-> i_stat.slot_free)
        else $error("result loaded over a waiting result");

    a_cursor_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit == lsw_pkg::EM_CURSOR) |=> (r_state == lsw_pkg::S_DATA))
        else $error("set cursor not followed by data write");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsw_pkg::S_CLEAR && i_stat.sweep_done) |=> (r_state == lsw_pkg::S_ONE))
        else $error("clear sweep did not end in clear command");

endmodule

FILE: rtl/lcd_shadow_write_filter.sv
`timescale 1ns / 1ps

// shadow-buffer write filter for a character lcd: keeps a copy of every screen
// cell in a small single-port ram, drops character writes that would not change
// the screen and re-sends the cursor position before the next real data write
// whenever the display's own cursor may be out of step (after a dropped write,
// a line wrap or a cursor pulled back into the area in use). set cursor, clear
// and home are passed on; clear also fills the copy with spaces and homes the
// cursor. a set cursor or home request is accepted, then sent on; a character
// write is accepted, then compared against the registered ram read, with a set
// cursor sent first when one is needed; a clear is accepted, then the ram is
// swept one cell a cycle, then the clear command goes out. after reset a
// clearing pass over all 80 cells runs before the first request is taken
// (configuration writes are taken at any time). a new request is taken while
// the last result still waits in the output register; a stalled result only
// holds up the next request that has a result to send

module lcd_shadow_write_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lsw_req_if.sink                     i_req,
    lsw_res_if.source                   o_res,
    // configuration: num_cols at 0x0, num_rows at 0x4
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsw_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsw_pkg::DATA_W-1:0]  pwdata,
    output logic [lsw_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    lsw_pkg::t_cfg     cfg;
    lsw_pkg::t_dp_cmd  dp_cmd;
    lsw_pkg::t_dp_stat dp_stat;
    lsw_pkg::t_kind    req_kind;

    assign req_kind = lsw_pkg::t_kind'(i_req.kind);

    // register file with size saturation
    lsw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: sweeps, compare, result ordering
    lsw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_kind  (req_kind),
        .o_ready (i_req.ready),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // shadow ram, cursor and result register
    lsw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg       (cfg),
        .i_kind      (req_kind),
        .i_char      (i_req.char_code),
        .i_col       (i_req.col),
        .i_row       (i_req.row),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_command   (o_res.command),
        .o_out_col   (o_res.out_col),
        .o_out_row   (o_res.out_row),
        .o_out_char  (o_res.out_char),
        .o_last      (o_res.last)
    );

endmodule
